>>> rtl/core/dcb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the draw command batcher.
// Used by every module of the batcher core; depends on nothing.
package dcb_pkg;

  localparam int COUNT_W    = 16;
  localparam int ELEMENTS_W = 24;
  localparam int TEXTURE_W  = 32;
  localparam int NUM_TYPES  = 4;

  localparam logic [TEXTURE_W-1:0] NO_TEXTURE = {TEXTURE_W{1'b1}};

  typedef enum logic [1:0] {
    TYPE_QUAD      = 2'd0,
    TYPE_MESH      = 2'd1,
    TYPE_PRIMITIVE = 2'd2,
    TYPE_CURVE     = 2'd3
  } cmd_type_t;

  typedef enum logic {
    OP_DRAW  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef struct packed {
    op_t                    op;
    cmd_type_t              cmd_type;
    logic [TEXTURE_W-1:0]   texture;
    logic [COUNT_W-1:0]     count;
  } cmd_t;

  typedef struct packed {
    cmd_type_t              batch_type;
    logic [TEXTURE_W-1:0]   texture;
    logic [COUNT_W-1:0]     start;
    logic [ELEMENTS_W-1:0]  elements;
    logic                   frame_end;
  } batch_t;

endpackage

>>> rtl/core/draw_command_batcher_core.sv
`timescale 1ns / 1ps
// Draw command batcher core: groups a frame's draw commands into batches that share a type and
// texture (untextured commands join any open batch), with per-type instance start indices.
// A command word is taken every clock cycle while in_stall is low; the word closing a batch
// passes the s1 register and its batch word goes to the output register. Reset, or out_stall
// with both registers full, stalls input. Depends on dcb_pkg, dcb_inst_ctr, dcb_batch_unit.
module draw_command_batcher_core #(
  parameter int MAX_COMMANDS     = 65536,
  parameter int ELEMENT_SUM_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [1:0]          cmd_type,
  input  logic signed [31:0]  texture_id,
  input  logic [15:0]         element_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          batch_type,
  output logic signed [31:0]  batch_texture,
  output logic [15:0]         batch_start,
  output logic [23:0]         batch_elements,
  output logic                frame_end
);

  localparam int CapBits = (ELEMENT_SUM_BITS < dcb_pkg::ELEMENTS_W) ?
                           ELEMENT_SUM_BITS : dcb_pkg::ELEMENTS_W;
  localparam logic [dcb_pkg::ELEMENTS_W-1:0] ElemCap =
    {dcb_pkg::ELEMENTS_W{1'b1}} >> (dcb_pkg::ELEMENTS_W - CapBits);
  localparam int WrapAt = (MAX_COMMANDS < (1 << dcb_pkg::COUNT_W)) ?
                          MAX_COMMANDS : (1 << dcb_pkg::COUNT_W);

  logic                          s1_valid;
  dcb_pkg::cmd_t                 s1_cmd;
  logic                          s1_adv;
  logic                          step;
  logic                          emit;
  logic [dcb_pkg::COUNT_W-1:0]   type_count;
  dcb_pkg::batch_t               batch;
  dcb_pkg::batch_t               out_batch;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = rst || (s1_valid && !s1_adv);
  assign step     = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd <= '{op: dcb_pkg::op_t'(op), cmd_type: dcb_pkg::cmd_type_t'(cmd_type),
                  texture: $unsigned(texture_id), count: element_count};
    end
  end

  dcb_inst_ctr #(
    .WrapAt (WrapAt)
  ) u_inst_ctr (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .flush (s1_cmd.op == dcb_pkg::OP_FLUSH),
    .sel   (s1_cmd.cmd_type),
    .count (type_count)
  );

  dcb_batch_unit #(
    .ElemCap (ElemCap)
  ) u_batch_unit (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .cmd        (s1_cmd),
    .type_count (type_count),
    .emit       (emit),
    .batch      (batch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_batch <= batch;
    end
  end

  assign batch_type     = out_batch.batch_type;
  assign batch_texture  = $signed(out_batch.texture);
  assign batch_start    = out_batch.start;
  assign batch_elements = out_batch.elements;
  assign frame_end      = out_batch.frame_end;

endmodule

>>> rtl/core/dcb_inst_ctr.sv
`timescale 1ns / 1ps
// Per-type instance counters of the draw command batcher.
// Depends on dcb_pkg.
module dcb_inst_ctr #(
  parameter int WrapAt = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          flush,
  input  dcb_pkg::cmd_type_t            sel,
  output logic [dcb_pkg::COUNT_W-1:0]   count
);

  localparam logic [dcb_pkg::COUNT_W:0] WrapLimit = (dcb_pkg::COUNT_W + 1)'(WrapAt);

  logic [dcb_pkg::COUNT_W-1:0] cnt [dcb_pkg::NUM_TYPES];
  logic [dcb_pkg::COUNT_W:0]   inc;
  logic [dcb_pkg::COUNT_W-1:0] cnt_next;

  assign count = cnt[sel];
  assign inc   = {1'b0, cnt[sel]} + {{dcb_pkg::COUNT_W{1'b0}}, 1'b1};

  always_comb begin
    if (inc >= WrapLimit) begin
      cnt_next = '0;
    end else begin
      cnt_next = inc[dcb_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dcb_pkg::NUM_TYPES; i++) begin
        cnt[i] <= '0;
      end
    end else if (step) begin
      if (flush) begin
        for (int i = 0; i < dcb_pkg::NUM_TYPES; i++) begin
          cnt[i] <= '0;
        end
      end else begin
        cnt[sel] <= cnt_next;
      end
    end
  end

endmodule

>>> rtl/core/dcb_batch_unit.sv
`timescale 1ns / 1ps
// Open batch register and merge decision of the draw command batcher.
// Depends on dcb_pkg.
module dcb_batch_unit #(
  parameter logic [dcb_pkg::ELEMENTS_W-1:0] ElemCap = {dcb_pkg::ELEMENTS_W{1'b1}}
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  dcb_pkg::cmd_t                 cmd,
  input  logic [dcb_pkg::COUNT_W-1:0]   type_count,
  output logic                          emit,
  output dcb_pkg::batch_t               batch
);

  logic                            open_valid;
  dcb_pkg::cmd_type_t              open_type;
  logic [dcb_pkg::TEXTURE_W-1:0]   open_texture;
  logic [dcb_pkg::COUNT_W-1:0]     open_start;
  logic [dcb_pkg::ELEMENTS_W-1:0]  open_elements;

  logic                            is_flush;
  logic                            single;
  logic                            merge;
  logic [dcb_pkg::ELEMENTS_W-1:0]  elems_raw;
  logic [dcb_pkg::ELEMENTS_W-1:0]  elems;
  logic [dcb_pkg::ELEMENTS_W:0]    sum;
  logic [dcb_pkg::ELEMENTS_W-1:0]  sum_sat;

  always_comb begin
    is_flush  = (cmd.op == dcb_pkg::OP_FLUSH);
    single    = (cmd.cmd_type == dcb_pkg::TYPE_QUAD) ||
                (cmd.cmd_type == dcb_pkg::TYPE_PRIMITIVE);
    elems_raw = single ? dcb_pkg::ELEMENTS_W'(1)
                       : {{(dcb_pkg::ELEMENTS_W-dcb_pkg::COUNT_W){1'b0}}, cmd.count};
    elems     = (elems_raw > ElemCap) ? ElemCap : elems_raw;
    merge     = open_valid &&
                (((cmd.cmd_type == open_type) && (cmd.texture == open_texture)) ||
                 (cmd.texture == dcb_pkg::NO_TEXTURE));
    sum       = {1'b0, open_elements} + {1'b0, elems};
    sum_sat   = (sum > {1'b0, ElemCap}) ? ElemCap : sum[dcb_pkg::ELEMENTS_W-1:0];
    emit      = step && open_valid && (is_flush || !merge);
    batch     = '{batch_type: open_type, texture: open_texture, start: open_start,
                  elements: open_elements, frame_end: is_flush};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_valid <= 1'b0;
    end else if (step) begin
      open_valid <= !is_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !is_flush) begin
      if (merge) begin
        open_elements <= sum_sat;
      end else begin
        open_type     <= cmd.cmd_type;
        open_texture  <= cmd.texture;
        open_start    <= type_count;
        open_elements <= elems;
      end
    end
  end

endmodule

>>> rtl/core/dcb_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the draw command batcher core, attached by bind.
// Depends on draw_command_batcher_core.
module dcb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          batch_type,
  input logic signed [31:0]  batch_texture,
  input logic [15:0]         batch_start,
  input logic [23:0]         batch_elements,
  input logic                frame_end
);

  // A waiting batch word must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(batch_type) && $stable(batch_texture) &&
      $stable(batch_start) && $stable(batch_elements) && $stable(frame_end))
    else $error("batch word changed while stalled");

  // The input is only held back by a stalled batch word.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled batch word");

  // A new batch word comes from an accepted input word that has passed the s1 and output registers.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("batch word without an accepted input word");

  // Reset leaves no batch word pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("batch word pending after reset");

endmodule

bind draw_command_batcher_core dcb_checker u_dcb_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for draw_command_batcher_core: a table of directed words, a long merge
// frame, then random frames, checked by a model of the batcher held here or, in the table,
// by listed batches. Depends on dcb_pkg and the batcher core RTL.
module tb_top;
  import dcb_pkg::*;

  localparam int RANDOM_WORDS = 1300;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int HOLD_CYCLES  = 300;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_BATCH
  } chk_t;

  typedef struct {
    op_t              op;
    cmd_type_t        ct;
    logic [31:0]      tex;
    logic [15:0]      cnt;
    chk_t             chk;
    batch_t           want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = 1'b0;
  logic [1:0]         cmd_type = 2'd0;
  logic signed [31:0] texture_id = 32'sd0;
  logic [15:0]        element_count = 16'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         batch_type;
  logic signed [31:0] batch_texture;
  logic [15:0]        batch_start;
  logic [23:0]        batch_elements;
  logic               frame_end;

  draw_command_batcher_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .cmd_type       (cmd_type),
    .texture_id     (texture_id),
    .element_count  (element_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .batch_type     (batch_type),
    .batch_texture  (batch_texture),
    .batch_start    (batch_start),
    .batch_elements (batch_elements),
    .frame_end      (frame_end)
  );

  // Model state of the open batch and the per-type instance counters.
  logic               open_live;
  cmd_type_t          open_type;
  logic [31:0]        open_tex;
  logic [15:0]        open_start;
  logic [23:0]        open_elems;
  logic [15:0]        inst_count [NUM_TYPES];

  batch_t             pending_batches [$];
  row_t               plan [$];
  int                 bad_words = 0;
  int                 cycle_count = 0;
  int                 rx_wait = 0;
  bit                 tx_idles = 1'b1;
  bit                 rx_idles = 1'b1;
  bit                 pressure_go = 1'b0;
  logic               hold_out = 1'b0;

  function automatic void add_row(input row_t r);
    plan = {plan, r};
  endfunction

  function automatic void note_batch(input batch_t b);
    pending_batches = {pending_batches, b};
  endfunction

  function automatic bit step_batcher(input op_t o, input cmd_type_t t, input logic [31:0] tx,
                                      input logic [15:0] c, output batch_t b);
    logic [23:0] add;
    logic [24:0] sum;
    bit hit;
    hit = 1'b0;
    b = '0;
    if (o == OP_FLUSH) begin
      if (open_live) begin
        b = '{open_type, open_tex, open_start, open_elems, 1'b1};
        hit = 1'b1;
      end
      open_live = 1'b0;
      open_type = TYPE_QUAD;
      open_tex = '0;
      open_start = '0;
      open_elems = '0;
      foreach (inst_count[i]) inst_count[i] = '0;
    end else begin
      add = (t == TYPE_QUAD || t == TYPE_PRIMITIVE) ? 24'd1 : {8'd0, c};
      if (open_live && ((t == open_type && tx == open_tex) || tx == NO_TEXTURE)) begin
        sum = {1'b0, open_elems} + {1'b0, add};
        open_elems = sum[24] ? '1 : sum[23:0];
      end else begin
        if (open_live) begin
          b = '{open_type, open_tex, open_start, open_elems, 1'b0};
          hit = 1'b1;
        end
        open_live = 1'b1;
        open_type = t;
        open_tex = tx;
        open_start = inst_count[t];
        open_elems = add;
      end
      inst_count[t] = inst_count[t] + 16'd1;
    end
    return hit;
  endfunction

  task automatic send_word(input op_t o, input cmd_type_t t, input logic [31:0] tx,
                           input logic [15:0] c, input chk_t chk, input batch_t want);
    int gap;
    bit hit;
    batch_t got;
    gap = tx_idles ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    cmd_type <= t;
    texture_id <= tx;
    element_count <= c;
    do @(posedge clk); while (in_stall);
    hit = step_batcher(o, t, tx, c, got);
    if (chk == CHK_MODEL && hit) note_batch(got);
    if (chk == CHK_BATCH) note_batch(want);
  endtask

  task automatic check_batch();
    batch_t want;
    if (pending_batches.size() == 0) begin
      bad_words++;
      if (bad_words <= 10)
        $display("unexpected batch word: type %0d texture %0d start %0d elements %0d end %0b",
                 batch_type, batch_texture, batch_start, batch_elements, frame_end);
    end else begin
      want = pending_batches.pop_front();
      if (batch_type !== want.batch_type || batch_texture !== want.texture ||
          batch_start !== want.start || batch_elements !== want.elements ||
          frame_end !== want.frame_end) begin
        bad_words++;
        if (bad_words <= 10)
          $display("batch word mismatch: expected %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                   want.batch_type, $signed(want.texture), want.start, want.elements,
                   want.frame_end, batch_type, batch_texture, batch_start, batch_elements,
                   frame_end);
      end
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_batch();
        rx_wait = rx_idles ? $urandom_range(0, 3) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= hold_out || (rx_wait > 0);
    end
  end

  // The receiver holds off for a long stretch so that the core fills up and stalls its input.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] tex_pool [3];
    cmd_type_t   fav;
    cmd_type_t   t;
    op_t         o;
    logic [31:0] tx;
    logic [15:0] c;
    int          sent;
    int          frame_len;
    int          roll;

    open_live = 1'b0;
    open_type = TYPE_QUAD;
    open_tex = '0;
    open_start = '0;
    open_elems = '0;
    foreach (inst_count[i]) inst_count[i] = '0;

    add_row('{OP_DRAW, TYPE_QUAD, 32'd5, 16'hFFFF, CHK_NONE, '0});
    add_row('{OP_DRAW, TYPE_QUAD, 32'd5, 16'h0000, CHK_NONE, '0});
    add_row('{OP_DRAW, TYPE_MESH, NO_TEXTURE, 16'hFFFF, CHK_NONE, '0});
    add_row('{OP_DRAW, TYPE_MESH, 32'd5, 16'd100, CHK_BATCH,
              '{TYPE_QUAD, 32'd5, 16'd0, 24'd65537, 1'b0}});
    add_row('{OP_FLUSH, TYPE_QUAD, 32'd0, 16'd0, CHK_BATCH,
              '{TYPE_MESH, 32'd5, 16'd1, 24'd100, 1'b1}});
    add_row('{OP_FLUSH, TYPE_CURVE, 32'h1234_5678, 16'hFFFF, CHK_NONE, '0});
    add_row('{OP_DRAW, TYPE_PRIMITIVE, 32'h7FFF_FFFF, 16'd1234, CHK_NONE, '0});
    add_row('{OP_DRAW, TYPE_CURVE, 32'h7FFF_FFFF, 16'h0000, CHK_BATCH,
              '{TYPE_PRIMITIVE, 32'h7FFF_FFFF, 16'd0, 24'd1, 1'b0}});
    add_row('{OP_DRAW, TYPE_CURVE, 32'h7FFF_FFFF, 16'hFFFF, CHK_NONE, '0});
    add_row('{OP_FLUSH, TYPE_CURVE, 32'h1234_5678, 16'hFFFF, CHK_BATCH,
              '{TYPE_CURVE, 32'h7FFF_FFFF, 16'd0, 24'd65535, 1'b1}});
    add_row('{OP_DRAW, TYPE_MESH, NO_TEXTURE, 16'd7, CHK_NONE, '0});
    add_row('{OP_DRAW, TYPE_QUAD, NO_TEXTURE, 16'd9, CHK_NONE, '0});
    add_row('{OP_DRAW, TYPE_QUAD, 32'd0, 16'd3, CHK_BATCH,
              '{TYPE_MESH, NO_TEXTURE, 16'd0, 24'd8, 1'b0}});
    add_row('{OP_DRAW, TYPE_QUAD, 32'd0, 16'd0, CHK_MODEL, '0});
    add_row('{OP_DRAW, TYPE_PRIMITIVE, 32'd0, 16'hFFFF, CHK_BATCH,
              '{TYPE_QUAD, 32'd0, 16'd1, 24'd2, 1'b0}});
    add_row('{OP_DRAW, TYPE_MESH, 32'd2, 16'd1, CHK_MODEL, '0});
    add_row('{OP_DRAW, TYPE_MESH, 32'd2, 16'd0, CHK_MODEL, '0});
    add_row('{OP_DRAW, TYPE_CURVE, 32'd2, 16'd5, CHK_MODEL, '0});
    add_row('{OP_FLUSH, TYPE_MESH, 32'h5555_AAAA, 16'hAAAA, CHK_MODEL, '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_word(plan[i].op, plan[i].ct, plan[i].tex, plan[i].cnt, plan[i].chk, plan[i].want);

    // Enough large mesh words to drive the element sum into saturation.
    tx_idles = 1'b0;
    rx_idles = 1'b0;
    repeat (260) send_word(OP_DRAW, TYPE_MESH, 32'd3, 16'hFFFF, CHK_MODEL, '0);
    repeat (3) send_word(OP_DRAW, TYPE_CURVE, NO_TEXTURE, 16'hFFFF, CHK_MODEL, '0);
    send_word(OP_FLUSH, TYPE_QUAD, 32'd0, 16'd0, CHK_MODEL, '0);

    tx_idles = 1'b1;
    rx_idles = 1'b1;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      frame_len = $urandom_range(1, 24);
      fav = cmd_type_t'($urandom_range(0, 3));
      tex_pool[0] = $urandom_range(0, 3);
      tex_pool[1] = $urandom() & 32'h7FFF_FFFF;
      tex_pool[2] = $urandom_range(0, 3);
      for (int k = 0; k < frame_len; k++) begin
        o = ($urandom_range(0, 99) < 3) ? OP_FLUSH : OP_DRAW;
        t = $urandom_range(0, 1) ? fav : cmd_type_t'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 20) tx = NO_TEXTURE;
        else if (roll < 90) tx = tex_pool[$urandom_range(0, 2)];
        else tx = $urandom() & 32'h7FFF_FFFF;
        case ($urandom_range(0, 3))
          0: c = 16'h0000;
          1: c = 16'hFFFF;
          2: c = 16'($urandom_range(0, 15));
          default: c = 16'($urandom());
        endcase
        send_word(o, t, tx, c, CHK_MODEL, '0);
        sent++;
        if (sent % 200 == 0) begin
          tx_idles = $urandom_range(0, 2) != 0;
          rx_idles = $urandom_range(0, 2) != 0;
        end
        if (sent >= 400) pressure_go = 1'b1;
      end
      if ($urandom_range(0, 9) != 0) begin
        send_word(OP_FLUSH, cmd_type_t'($urandom_range(0, 3)), $urandom() & 32'h7FFF_FFFF,
                  16'($urandom()), CHK_MODEL, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_batches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_words == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
